/* hdl/sfsq_pkg.sv */
// Shared constants and types for the single filled square check unit.
`default_nettype none
package sfsq_pkg;
   localparam int unsigned MAX_SIDE_DEFAULT = 32;
   localparam int unsigned GRID_SIDE_W      = 6;
   localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RESET = 6'd32;
   localparam int unsigned SIDE_OUT_W       = 6;
   localparam int unsigned COUNT_OUT_W      = 11;

   typedef struct packed {
      logic filled;
      logic first_row;
      logic row_end;
      logic grid_end;
   } sfsq_item_ctl_type;
endpackage
`default_nettype wire

/* hdl/sfsq_row_store.sv */
// Line store of square sides for the row above, with read-after-write forwarding.
`default_nettype none
module sfsq_row_store #(
   parameter int unsigned MAX_SIDE = 32,
   parameter int unsigned COL_W    = 5,
   parameter int unsigned VAL_W    = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [COL_W-1:0] rd_addr,
   input  wire logic             wr_en,
   input  wire logic [COL_W-1:0] wr_addr,
   input  wire logic [VAL_W-1:0] wr_data,
   output logic      [VAL_W-1:0] rd_data
);
   logic [VAL_W-1:0] mem [MAX_SIDE];
   logic [VAL_W-1:0] rd_data_ff;
   logic [VAL_W-1:0] fwd_data_ff;
   logic             fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // Remember a same-entry write so the read sees the new value.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
endmodule
`default_nettype wire

/* hdl/sfsq_cell_datapath.sv */
// Per-cell square side update, running totals and per-grid verdict.
`default_nettype none
module sfsq_cell_datapath #(
   parameter int unsigned VAL_W = 6,
   parameter int unsigned CNT_W = 11
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       clear,
   input  wire logic                       advance,
   input  wire sfsq_pkg::sfsq_item_ctl_type ctl,
   input  wire logic [VAL_W-1:0]           up_value,
   output logic      [VAL_W-1:0]           cur_value,
   output logic                            res_single,
   output logic      [VAL_W-1:0]           res_largest,
   output logic      [CNT_W-1:0]           res_count
);
   import sfsq_pkg::*;

   localparam int unsigned SQ_W = 2 * VAL_W;

   logic [VAL_W-1:0] left_ff, left_in;
   logic [VAL_W-1:0] diag_ff, diag_in;
   logic [VAL_W-1:0] largest_ff, largest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] up_eff;
   logic [VAL_W-1:0] min_lu;
   logic [VAL_W-1:0] min_all;
   logic [VAL_W-1:0] largest_nx;
   logic [CNT_W-1:0] count_nx;
   logic [SQ_W-1:0]  square;

   always_comb begin
      // The first row of a grid sees an empty row above.
      up_eff     = ctl.first_row ? '0 : up_value;
      min_lu     = (left_ff < up_eff) ? left_ff : up_eff;
      min_all    = (min_lu < diag_ff) ? min_lu : diag_ff;
      cur_value  = ctl.filled ? (min_all + VAL_W'(1)) : '0;
      largest_nx = (cur_value > largest_ff) ? cur_value : largest_ff;
      count_nx   = count_ff + CNT_W'(ctl.filled);
      square     = SQ_W'(largest_nx) * SQ_W'(largest_nx);

      res_single  = (square == SQ_W'(count_nx));
      res_largest = largest_nx;
      res_count   = count_nx;

      left_in    = left_ff;
      diag_in    = diag_ff;
      largest_in = largest_ff;
      count_in   = count_ff;
      if (advance) begin
         if (ctl.grid_end) begin
            left_in    = '0;
            diag_in    = '0;
            largest_in = '0;
            count_in   = '0;
         end else if (ctl.row_end) begin
            left_in    = '0;
            diag_in    = '0;
            largest_in = largest_nx;
            count_in   = count_nx;
         end else begin
            left_in    = cur_value;
            diag_in    = up_eff;
            largest_in = largest_nx;
            count_in   = count_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         left_ff    <= '0;
         diag_ff    <= '0;
         largest_ff <= '0;
         count_ff   <= '0;
      end else begin
         left_ff    <= left_in;
         diag_ff    <= diag_in;
         largest_ff <= largest_in;
         count_ff   <= count_in;
      end
   end
endmodule
`default_nettype wire

/* hdl/single_filled_square_check_unit.sv */
// Top level of the single filled square check unit.
// Throughput: one pixel item per cycle; the input stalls only behind an untaken result.
// Result path: the last pixel of a grid waits in the update stage, and its result is loaded into the output register.
// Reset: synchronous, active high; grid side returns to 32 and the grid restarts.
//   The line store is not swept: the first row of each grid reads it as zero.
`default_nettype none
module single_filled_square_check_unit #(
   parameter int unsigned MAX_SIDE = sfsq_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_pixel_filled,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_is_single_square,
   output logic [sfsq_pkg::SIDE_OUT_W-1:0]          rsp_largest_square_side,
   output logic [sfsq_pkg::COUNT_OUT_W-1:0]         rsp_filled_cell_count,
   input  wire logic                                csr_write_en,
   input  wire logic [sfsq_pkg::GRID_SIDE_W-1:0]    csr_write_data
);
   import sfsq_pkg::*;

   localparam int unsigned COL_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int unsigned VAL_W = $clog2(MAX_SIDE + 1);
   localparam int unsigned CNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);

   // Configuration and scan position.
   logic [GRID_SIDE_W-1:0] grid_side_ff;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [COL_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       last_idx;
   logic                   row_end_a;
   logic                   grid_end_a;
   logic                   accept;

   // Update stage: holds one item while its line store read completes.
   logic                   b_valid_ff;
   sfsq_item_ctl_type      b_ctl_ff;
   logic [COL_W-1:0]       b_col_ff;
   logic                   b_adv;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_single_ff;
   logic [VAL_W-1:0]       rsp_largest_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic [VAL_W-1:0]       up_value;
   logic [VAL_W-1:0]       cur_value;
   logic                   res_single;
   logic [VAL_W-1:0]       res_largest;
   logic [CNT_W-1:0]       res_count;

   // Clamp the grid side: zero acts as one, anything above the store depth as the depth.
   always_comb begin
      if (grid_side_ff == '0) begin
         last_idx = '0;
      end else if (int'(grid_side_ff) > int'(MAX_SIDE)) begin
         last_idx = COL_W'(MAX_SIDE - 1);
      end else begin
         last_idx = COL_W'(grid_side_ff - GRID_SIDE_W'(1));
      end
   end

   assign row_end_a  = (col_ff == last_idx);
   assign grid_end_a = row_end_a && (row_ff == last_idx);

   // Stall the update stage only when a finished grid cannot enter the output register.
   assign b_adv     = b_valid_ff && (!b_ctl_ff.grid_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !b_valid_ff || b_adv;
   assign accept    = req_valid && req_ready;

   // Advance the scan position on every accepted item.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end_a) begin
            col_in = '0;
            row_in = grid_end_a ? '0 : (row_ff + COL_W'(1));
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= GRID_SIDE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         b_valid_ff   <= 1'b0;
      end else if (csr_write_en) begin
         // A side change restarts the grid; drop any partial grid.
         grid_side_ff <= csr_write_data;
         col_ff       <= '0;
         row_ff       <= '0;
         b_valid_ff   <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            b_valid_ff <= 1'b1;
         end else if (b_adv) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   // Item payload into the update stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         b_ctl_ff.filled    <= req_pixel_filled;
         b_ctl_ff.first_row <= (row_ff == '0);
         b_ctl_ff.row_end   <= row_end_a;
         b_ctl_ff.grid_end  <= grid_end_a;
         b_col_ff           <= col_ff;
      end
   end

   sfsq_row_store #(
      .MAX_SIDE (MAX_SIDE),
      .COL_W    (COL_W),
      .VAL_W    (VAL_W)
   ) u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (b_adv),
      .wr_addr (b_col_ff),
      .wr_data (cur_value),
      .rd_data (up_value)
   );

   sfsq_cell_datapath #(
      .VAL_W (VAL_W),
      .CNT_W (CNT_W)
   ) u_cell_datapath (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_write_en),
      .advance     (b_adv),
      .ctl         (b_ctl_ff),
      .up_value    (up_value),
      .cur_value   (cur_value),
      .res_single  (res_single),
      .res_largest (res_largest),
      .res_count   (res_count)
   );

   // Hold the result until taken; load it when the last cell of a grid retires.
   always_ff @(posedge clock) begin
      if (reset || csr_write_en) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_adv && b_ctl_ff.grid_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv && b_ctl_ff.grid_end) begin
         rsp_single_ff  <= res_single;
         rsp_largest_ff <= res_largest;
         rsp_count_ff   <= res_count;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_is_single_square    = rsp_single_ff;
   assign rsp_largest_square_side = SIDE_OUT_W'(rsp_largest_ff);
   assign rsp_filled_cell_count   = COUNT_OUT_W'(rsp_count_ff);

   // The update stage stalls only behind an untaken result.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_adv) |-> (rsp_valid_ff && !rsp_ready && b_ctl_ff.grid_end))
      else $error("update stage stalled without a pending result");

   // An empty update stage never refuses an item.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !b_valid_ff |-> req_ready)
      else $error("input refused with empty update stage");

   // A grid with no filled cell reports yes with zero side.
   a_empty_grid : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_count_ff == '0)) |-> (rsp_single_ff && (rsp_largest_ff == '0)))
      else $error("empty grid result inconsistent");

   // A nonzero side implies at least that many filled cells squared.
   a_side_vs_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((2 * CNT_W)'(rsp_largest_ff) * (2 * CNT_W)'(rsp_largest_ff)
                        <= (2 * CNT_W)'(rsp_count_ff)))
      else $error("largest side exceeds filled count");
endmodule
`default_nettype wire
